/* sv/dcq_pkg.sv */
package dcq_pkg;

    localparam int COEF_BITS       = 16;
    localparam int ALPHA_FRAC_BITS = 8;
    localparam int QUAL_W          = 7;
    localparam int TAB_W           = 7;
    // alpha peaks at 50 * 2^F, which stays below 64 * 2^F
    localparam int ALPHA_W         = ALPHA_FRAC_BITS + 6;
    localparam int STEP_W          = ALPHA_W + TAB_W;
    localparam int NUM_W           = COEF_BITS + ALPHA_FRAC_BITS + 2;
    localparam int REM_W           = STEP_W + 1;
    localparam int PROD_W          = COEF_BITS + STEP_W;
    localparam int PRE_STAGES      = 3;
    localparam int PIPE_DEPTH      = PRE_STAGES + NUM_W;
    localparam int ACNT_W          = $clog2(ALPHA_W);

    localparam logic [QUAL_W-1:0] QUALITY_RESET = QUAL_W'(50);
    localparam logic [QUAL_W-1:0] QUALITY_KNEE  = QUAL_W'(50);
    localparam logic [QUAL_W-1:0] QUALITY_MAX   = QUAL_W'(100);
    localparam logic [QUAL_W-1:0] QUALITY_MIN   = QUAL_W'(1);
    localparam logic [ALPHA_W-1:0] ALPHA_RESET =
        ALPHA_W'(((100 - 50) * (1 << ALPHA_FRAC_BITS) + 25) / 50);
    localparam logic [ALPHA_W-1:0] ALPHA_NUM_LOW = ALPHA_W'(50 * (1 << ALPHA_FRAC_BITS));
    localparam logic [ALPHA_W-1:0] ALPHA_HALF_HIGH = ALPHA_W'(25);

    localparam logic [TAB_W-1:0] LUMA_TAB [64] = '{
        7'd16, 7'd11, 7'd10, 7'd16, 7'd24,  7'd40,  7'd51,  7'd61,
        7'd12, 7'd12, 7'd14, 7'd19, 7'd26,  7'd58,  7'd60,  7'd55,
        7'd14, 7'd13, 7'd16, 7'd24, 7'd40,  7'd57,  7'd69,  7'd56,
        7'd14, 7'd17, 7'd22, 7'd29, 7'd51,  7'd87,  7'd80,  7'd62,
        7'd18, 7'd22, 7'd37, 7'd56, 7'd68,  7'd109, 7'd103, 7'd77,
        7'd24, 7'd35, 7'd55, 7'd64, 7'd81,  7'd104, 7'd113, 7'd92,
        7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
        7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
    };

    localparam logic [TAB_W-1:0] CHROMA_TAB [64] = '{
        7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
    };

    typedef enum logic {
        ALPHA_IDLE,
        ALPHA_DIV
    } t_alpha_state;

    typedef struct packed {
        logic               busy;
        logic [ALPHA_W-1:0] alpha;
    } t_alpha_stat;

    typedef struct packed {
        logic              neg;
        logic              mag_zero;
        logic              deq;
        logic              step_zero;
        logic [PROD_W-1:0] prod;
    } t_side;

    typedef struct packed {
        logic [COEF_BITS-1:0] val;
        logic                 clip;
    } t_lane_res;

    function automatic t_lane_res finish_lane(t_side s, logic [NUM_W-1:0] quo);
        t_lane_res               res;
        logic [PROD_W:0]         rounded;
        logic [PROD_W:0]         mag;
        logic [PROD_W:0]         limit;
        logic [COEF_BITS-1:0]    lo;
        res.clip = 1'b0;
        res.val  = '0;
        rounded  = (PROD_W + 1)'(s.prod) + (PROD_W + 1)'(1 << (ALPHA_FRAC_BITS - 1));
        if (s.deq) begin
            mag = rounded >> ALPHA_FRAC_BITS;
        end else begin
            mag = (PROD_W + 1)'(quo);
        end
        limit = s.neg ? (PROD_W + 1)'(1) << (COEF_BITS - 1)
                      : ((PROD_W + 1)'(1) << (COEF_BITS - 1)) - 1'b1;
        if (!s.deq && s.step_zero) begin
            // divide by zero: rail of the sign, 0 for zero input
            res.clip = 1'b1;
            mag      = s.mag_zero ? '0 : limit;
        end else if (mag > limit) begin
            res.clip = 1'b1;
            mag      = limit;
        end
        lo      = mag[COEF_BITS-1:0];
        res.val = s.neg ? (~lo + 1'b1) : lo;
        return res;
    endfunction

endpackage

/* sv/dcq_if.sv */
interface dcq_in_if;
    logic                                        valid;
    logic                                        ready;
    logic                                        cmd;
    logic [2:0]                                  col;
    logic [2:0]                                  row;
    logic signed [dcq_pkg::COEF_BITS-1:0]        luma_in;
    logic signed [dcq_pkg::COEF_BITS-1:0]        chroma_b_in;
    logic signed [dcq_pkg::COEF_BITS-1:0]        chroma_r_in;

    modport source (output valid, cmd, col, row, luma_in, chroma_b_in, chroma_r_in,
                    input ready);
    modport sink (input valid, cmd, col, row, luma_in, chroma_b_in, chroma_r_in,
                  output ready);
endinterface

interface dcq_out_if;
    logic                                        valid;
    logic                                        ready;
    logic signed [dcq_pkg::COEF_BITS-1:0]        luma_out;
    logic signed [dcq_pkg::COEF_BITS-1:0]        chroma_b_out;
    logic signed [dcq_pkg::COEF_BITS-1:0]        chroma_r_out;
    logic                                        clipped;

    modport source (output valid, luma_out, chroma_b_out, chroma_r_out, clipped,
                    input ready);
    modport sink (input valid, luma_out, chroma_b_out, chroma_r_out, clipped,
                  output ready);
endinterface

interface dcq_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dcq_pkg::QUAL_W-1:0]        data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* sv/dcq_alpha.sv */
module dcq_alpha (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dcq_cfg_if.sink               i_cfg,
    output dcq_pkg::t_alpha_stat  o_stat
);

    dcq_pkg::t_alpha_state                 r_state, n_state;
    logic [dcq_pkg::ALPHA_W-1:0]           r_alpha, n_alpha;
    logic [dcq_pkg::ALPHA_W-1:0]           r_num, n_num;
    logic [dcq_pkg::QUAL_W-1:0]            r_rem, n_rem;
    logic [dcq_pkg::QUAL_W-1:0]            r_den, n_den;
    logic [dcq_pkg::ACNT_W-1:0]            r_cnt, n_cnt;
    logic [dcq_pkg::QUAL_W-1:0]            q;
    logic [dcq_pkg::QUAL_W:0]              trial;
    logic                                  fits;

    always_comb begin
        n_state = r_state;
        n_alpha = r_alpha;
        n_num   = r_num;
        n_rem   = r_rem;
        n_den   = r_den;
        n_cnt   = r_cnt;
        q       = (i_cfg.data == '0) ? dcq_pkg::QUALITY_MIN : i_cfg.data;
        trial   = {r_rem, r_num[dcq_pkg::ALPHA_W-1]};
        fits    = trial >= {1'b0, r_den};
        i_cfg.ready = (r_state == dcq_pkg::ALPHA_IDLE);
        case (r_state)
            dcq_pkg::ALPHA_IDLE: begin
                if (i_cfg.valid) begin
                    n_rem   = '0;
                    n_cnt   = dcq_pkg::ACNT_W'(dcq_pkg::ALPHA_W - 1);
                    n_alpha = '0;
                    if (q >= dcq_pkg::QUALITY_MAX) begin
                        n_state = dcq_pkg::ALPHA_IDLE;
                    end else if (q < dcq_pkg::QUALITY_KNEE) begin
                        n_num   = dcq_pkg::ALPHA_NUM_LOW + dcq_pkg::ALPHA_W'(q >> 1);
                        n_den   = q;
                        n_state = dcq_pkg::ALPHA_DIV;
                    end else begin
                        n_num   = (dcq_pkg::ALPHA_W'(dcq_pkg::QUALITY_MAX - q)
                                   << dcq_pkg::ALPHA_FRAC_BITS) + dcq_pkg::ALPHA_HALF_HIGH;
                        n_den   = dcq_pkg::QUALITY_KNEE;
                        n_state = dcq_pkg::ALPHA_DIV;
                    end
                end
            end
            dcq_pkg::ALPHA_DIV: begin
                // one quotient bit per cycle, restoring
                n_num   = r_num << 1;
                n_rem   = fits ? dcq_pkg::QUAL_W'(trial - {1'b0, r_den})
                               : trial[dcq_pkg::QUAL_W-1:0];
                n_alpha = {r_alpha[dcq_pkg::ALPHA_W-2:0], fits};
                n_cnt   = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = dcq_pkg::ALPHA_IDLE;
                end
            end
            default: begin
                n_state = dcq_pkg::ALPHA_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcq_pkg::ALPHA_IDLE;
            r_alpha <= dcq_pkg::ALPHA_RESET;
        end else begin
            r_state <= n_state;
            r_alpha <= n_alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
    end

    assign o_stat.busy  = (r_state != dcq_pkg::ALPHA_IDLE);
    assign o_stat.alpha = r_alpha;

endmodule

/* sv/dcq_div_lane.sv */
module dcq_div_lane (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [dcq_pkg::NUM_W-1:0]    i_num,
    input  logic [dcq_pkg::REM_W-1:0]    i_den,
    input  dcq_pkg::t_side               i_side,
    output logic [dcq_pkg::NUM_W-1:0]    o_quo,
    output dcq_pkg::t_side               o_side
);

    localparam int N = dcq_pkg::NUM_W;

    logic [N-1:0]                  r_num  [N];
    logic [dcq_pkg::REM_W-1:0]     r_den  [N];
    logic [dcq_pkg::REM_W-1:0]     r_rem  [N];
    logic [N-1:0]                  r_quo  [N];
    dcq_pkg::t_side                r_side [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [N-1:0]                  num_in;
        logic [dcq_pkg::REM_W-1:0]     den_in;
        logic [dcq_pkg::REM_W-1:0]     rem_in;
        logic [N-1:0]                  quo_in;
        dcq_pkg::t_side                side_in;
        logic [dcq_pkg::REM_W:0]       trial;
        logic                          fits;
        logic [dcq_pkg::REM_W-1:0]     n_rem;
        logic [N-1:0]                  n_quo;

        if (k == 0) begin : g_first
            assign num_in  = i_num;
            assign den_in  = i_den;
            assign rem_in  = '0;
            assign quo_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign num_in  = r_num[k-1];
            assign den_in  = r_den[k-1];
            assign rem_in  = r_rem[k-1];
            assign quo_in  = r_quo[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            trial = {rem_in, num_in[N-1-k]};
            fits  = trial >= {1'b0, den_in};
            n_rem = fits ? dcq_pkg::REM_W'(trial - {1'b0, den_in})
                         : trial[dcq_pkg::REM_W-1:0];
            n_quo = quo_in;
            n_quo[N-1-k] = fits;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k]  <= num_in;
                r_den[k]  <= den_in;
                r_rem[k]  <= n_rem;
                r_quo[k]  <= n_quo;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_quo  = r_quo[N-1];
    assign o_side = r_side[N-1];

endmodule

/* sv/dct_coefficient_quantizer_top.sv */
// Quantizes or dequantizes the three coefficients (luma, chroma b, chroma r)
// of one 8x8 block position per transfer.
// i_in carries cmd (0 quantize, 1 dequantize), col, row and three signed
// 16-bit values; o_out returns the three results and a clipped flag, one
// result per input transfer, in order. i_cfg writes the 7-bit quality.
// Throughput: one item per cycle while no output stall or quality write
// holds i_in.ready low. Pipeline: 30 register stages (three front stages,
// one restoring divider stage per quotient bit over 26 bits, output
// register).
// A quality write below 100 occupies the alpha unit for its division,
// during which i_in.ready and i_cfg.ready stay low; only write quality
// while no item is in flight.
// Reset (synchronous, active low) empties the pipeline and sets quality
// 50. When o_out.ready is low with a result held, the whole pipeline
// freezes and i_in.ready drops; nothing is lost or repeated.
module dct_coefficient_quantizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dcq_in_if.sink      i_in,
    dcq_cfg_if.sink     i_cfg,
    dcq_out_if.source   o_out
);

    localparam int C = dcq_pkg::COEF_BITS;
    localparam int D = dcq_pkg::PIPE_DEPTH;

    dcq_pkg::t_alpha_stat              alpha_stat;
    logic                              en;
    logic                              acc;
    logic [D-1:0]                      r_vld;
    logic                              r_out_v;

    logic                              r1_cmd;
    logic [5:0]                        r1_pos;
    logic [C-1:0]                      r1_coef [3];

    logic                              r2_cmd;
    logic [C-1:0]                      r2_mag  [3];
    logic                              r2_neg  [3];
    logic [dcq_pkg::STEP_W-1:0]        r2_step [3];

    logic [dcq_pkg::NUM_W-1:0]         r3_num  [3];
    logic [dcq_pkg::REM_W-1:0]         r3_den  [3];
    dcq_pkg::t_side                    r3_side [3];

    logic [dcq_pkg::NUM_W-1:0]         quo     [3];
    dcq_pkg::t_side                    side_o  [3];
    dcq_pkg::t_lane_res                res     [3];
    logic [C-1:0]                      r_val   [3];
    logic                              r_clip;

    dcq_alpha u_alpha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_stat  (alpha_stat)
    );

    // advance everything together while the output slot is free or drains
    assign en         = !r_out_v || o_out.ready;
    assign i_in.ready = en && !alpha_stat.busy;
    assign acc        = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_vld   <= {r_vld[D-2:0], acc};
            r_out_v <= r_vld[D-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cmd     <= i_in.cmd;
            r1_pos     <= {i_in.col, i_in.row};
            r1_coef[0] <= i_in.luma_in;
            r1_coef[1] <= i_in.chroma_b_in;
            r1_coef[2] <= i_in.chroma_r_in;
            r2_cmd     <= r1_cmd;
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic [dcq_pkg::TAB_W-1:0] entry;
        logic [C-1:0]              mag;

        assign entry = (l == 0) ? dcq_pkg::LUMA_TAB[r1_pos] : dcq_pkg::CHROMA_TAB[r1_pos];
        assign mag   = r1_coef[l][C-1] ? (~r1_coef[l] + 1'b1) : r1_coef[l];

        always_ff @(posedge i_clk) begin
            if (en) begin
                r2_mag[l]  <= mag;
                r2_neg[l]  <= r1_coef[l][C-1];
                r2_step[l] <= dcq_pkg::STEP_W'(alpha_stat.alpha * entry);

                r3_num[l]  <= (dcq_pkg::NUM_W'(r2_mag[l]) << (dcq_pkg::ALPHA_FRAC_BITS + 1))
                              + dcq_pkg::NUM_W'(r2_step[l]);
                r3_den[l]  <= {r2_step[l], 1'b0};
                r3_side[l].neg       <= r2_neg[l];
                r3_side[l].mag_zero  <= (r2_mag[l] == '0);
                r3_side[l].deq       <= r2_cmd;
                r3_side[l].step_zero <= (r2_step[l] == '0);
                r3_side[l].prod      <= dcq_pkg::PROD_W'(r2_mag[l] * r2_step[l]);
            end
        end

        dcq_div_lane u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r3_num[l]),
            .i_den  (r3_den[l]),
            .i_side (r3_side[l]),
            .o_quo  (quo[l]),
            .o_side (side_o[l])
        );

        assign res[l] = dcq_pkg::finish_lane(side_o[l], quo[l]);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_val[l] <= res[l].val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_clip <= res[0].clip || res[1].clip || res[2].clip;
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.luma_out     = r_val[0];
    assign o_out.chroma_b_out = r_val[1];
    assign o_out.chroma_r_out = r_val[2];
    assign o_out.clipped      = r_clip;

`ifndef SYNTH
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alpha_stat.busy |-> !i_in.ready)
        else $error("input taken while alpha unit busy");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> $stable(r_vld))
        else $error("pipeline moved during output stall");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && (r_vld == '0))
        else $error("pipeline not empty after reset");
`endif

endmodule
